// ===== rtl/fthgr_pkg.sv =====
// shared types and constants for the force trigger with hysteresis and gain ramp
// no dependencies

package fthgr_pkg;

    localparam int DATA_W = 24;
    localparam int COEF_W = 16;
    localparam int LEN_W  = 9;
    localparam int ZCNT_W = 10;
    localparam int CFG_IDX_W = 3;

    localparam logic [ZCNT_W-1:0] ZERO_LIMIT = ZCNT_W'(500);
    localparam logic [ZCNT_W-1:0] ZERO_SAT   = ZCNT_W'(1023);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENTER_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXIT_THRESHOLD  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_COEFF    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_COEFF      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_STIFFNESS  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_DAMPING    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_FREE_DAMPING    = 3'd7;

    localparam logic [DATA_W-1:0] ENTER_THRESHOLD_RST = 24'd5120;
    localparam logic [DATA_W-1:0] EXIT_THRESHOLD_RST  = 24'd2560;
    localparam logic [LEN_W-1:0]  WINDOW_LENGTH_RST   = 9'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILT_MUL,
        ST_FILT_ACC,
        ST_CHECK,
        ST_DROP,
        ST_WRITE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_HYST,
        ST_STIFF_MUL,
        ST_STIFF_ACC,
        ST_DAMP_MUL,
        ST_DAMP_ACC,
        ST_OUT
    } state_t;

endpackage

// ===== rtl/fthgr_div.sv =====
// serial restoring divider, one quotient bit per cycle
// standalone, no package needed

module fthgr_div #(
    parameter int DIVIDEND_W = 33,
    parameter int DIVISOR_W  = 9
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  busy,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;

    logic [DIVISOR_W:0] rem_shift;
    logic [DIVISOR_W:0] rem_diff;
    logic               fits;

    assign rem_shift = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign rem_diff  = rem_shift - {1'b0, divisor};
    assign fits      = rem_shift >= {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(DIVIDEND_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so it fits the divisor width
            rem_reg <= fits ? rem_diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/force_trigger_hysteresis_gain_ramp_top.sv =====
// force trigger: low-pass, moving average, hysteresis and gain ramp on one shared multiplier
// depends on fthgr_pkg and fthgr_div

// One item is taken at a time; in_stall stays high while it is processed. A restart
// item goes straight to the output state. The first sample after a restart skips the
// filter accumulate step, and each window entry that is dropped (a full store, or a
// window shortened by a register write) adds a drop and a check step. The serial
// divider that forms the window mean takes most of a sample's time, one quotient bit
// per cycle; the filter blend and both ramp blends share one 17 x 25 multiplier. The
// result sits in an output register, so the next item can be taken while it waits.
// The user must write configuration only while idle; the block does not enforce it.

module force_trigger_hysteresis_gain_ramp_top #(
    parameter int WINDOW_MAX = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_we,
    input  logic [fthgr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fthgr_pkg::DATA_W-1:0]        cfg_data,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                func,
    input  logic [fthgr_pkg::DATA_W-1:0]        force_norm,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                is_free,
    output logic                                became_free,
    output logic                                became_held,
    output logic [fthgr_pkg::DATA_W-1:0]        filtered_norm,
    output logic [fthgr_pkg::DATA_W-1:0]        smoothed_norm,
    output logic [fthgr_pkg::DATA_W-1:0]        stiffness_out,
    output logic [fthgr_pkg::DATA_W-1:0]        damping_out,
    output logic                                zero_stuck
);

    localparam int DW   = fthgr_pkg::DATA_W;
    localparam int CWF  = fthgr_pkg::COEF_W;
    localparam int CW   = $clog2(WINDOW_MAX + 1);
    localparam int IW   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int SW   = DW + CW;
    localparam int LENW = (CW > fthgr_pkg::LEN_W) ? CW : fthgr_pkg::LEN_W;
    localparam int PW   = CWF + 1 + DW + 1;
    localparam int AW   = PW;

    // configuration registers
    logic [DW-1:0]                 enter_threshold_reg;
    logic [DW-1:0]                 exit_threshold_reg;
    logic [CWF-1:0]                filter_coeff_reg;
    logic [fthgr_pkg::LEN_W-1:0]   window_length_reg;
    logic [CWF-1:0]                ramp_coeff_reg;
    logic [DW-1:0]                 hold_stiffness_reg;
    logic [DW-1:0]                 hold_damping_reg;
    logic [DW-1:0]                 free_damping_reg;

    // block state
    fthgr_pkg::state_t             state_reg, state_next;
    logic                          free_flag_reg;
    logic                          filter_primed_reg;
    logic [DW-1:0]                 filter_value_reg;
    logic [SW-1:0]                 sum_reg;
    logic [CW-1:0]                 count_reg;
    logic [IW-1:0]                 head_reg;
    logic [IW-1:0]                 tail_reg;
    logic [DW-1:0]                 stiffness_reg;
    logic [DW-1:0]                 damping_reg;
    logic [fthgr_pkg::ZCNT_W-1:0]  zero_ticks_reg;

    // per-item working registers
    logic [DW-1:0]                 x_reg;
    logic                          written_reg;
    logic                          rise_reg;
    logic                          fall_reg;
    logic [DW-1:0]                 mean_reg;
    logic signed [PW-1:0]          prod_reg;
    logic [DW-1:0]                 rdata_reg;

    // output register
    logic                          out_valid_reg;
    logic                          is_free_reg;
    logic                          became_free_reg;
    logic                          became_held_reg;
    logic [DW-1:0]                 filtered_norm_reg;
    logic [DW-1:0]                 smoothed_norm_reg;
    logic [DW-1:0]                 stiffness_out_reg;
    logic [DW-1:0]                 damping_out_reg;
    logic                          zero_stuck_reg;

    logic [DW-1:0]                 window_mem [WINDOW_MAX];

    // control
    logic                          in_take;
    logic                          out_load;
    logic                          mem_we;
    logic                          div_start;
    logic                          div_busy;
    logic [SW-1:0]                 div_quotient;

    logic [LENW-1:0]               len_raw;
    logic [LENW-1:0]               len_eff;
    logic                          store_full;
    logic                          over_len;
    logic                          need_drop;

    // shared blend unit: y = (c*old + (65536-c)*new + 32768) >> 16
    logic [CWF-1:0]                bl_coeff;
    logic [DW-1:0]                 bl_old;
    logic [DW-1:0]                 bl_new;
    logic signed [DW:0]            bl_diff;
    logic signed [PW-1:0]          bl_prod;
    logic signed [AW-1:0]          bl_acc;
    logic [DW-1:0]                 bl_result;

    logic [DW-1:0]                 target_stiff;
    logic [DW-1:0]                 target_damp;

    assign target_stiff = free_flag_reg ? '0 : hold_stiffness_reg;
    assign target_damp  = free_flag_reg ? free_damping_reg : hold_damping_reg;

    always_comb
    begin
        unique case (state_reg)
            fthgr_pkg::ST_STIFF_MUL, fthgr_pkg::ST_STIFF_ACC:
            begin
                bl_coeff = ramp_coeff_reg;
                bl_old   = stiffness_reg;
                bl_new   = target_stiff;
            end
            fthgr_pkg::ST_DAMP_MUL, fthgr_pkg::ST_DAMP_ACC:
            begin
                bl_coeff = ramp_coeff_reg;
                bl_old   = damping_reg;
                bl_new   = target_damp;
            end
            default:
            begin
                bl_coeff = filter_coeff_reg;
                bl_old   = filter_value_reg;
                bl_new   = x_reg;
            end
        endcase
    end

    // rewritten as new + c*(old - new), so one multiply per blend
    assign bl_diff   = $signed({1'b0, bl_old}) - $signed({1'b0, bl_new});
    assign bl_prod   = $signed({1'b0, bl_coeff}) * bl_diff;
    assign bl_acc    = $signed({{(AW - DW - CWF){1'b0}}, bl_new, {CWF{1'b0}}})
                       + prod_reg + $signed(AW'(32768));
    assign bl_result = bl_acc[DW+CWF-1:CWF];

    // window length clamped to 1..WINDOW_MAX
    assign len_raw = LENW'(window_length_reg);
    always_comb
    begin
        priority if (len_raw == '0)
        begin
            len_eff = LENW'(1);
        end
        else if (len_raw > LENW'(WINDOW_MAX))
        begin
            len_eff = LENW'(WINDOW_MAX);
        end
        else
        begin
            len_eff = len_raw;
        end
    end

    assign store_full = count_reg == CW'(WINDOW_MAX);
    assign over_len   = LENW'(count_reg) > len_eff;
    assign need_drop  = written_reg ? over_len : store_full;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fthgr_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = func ? fthgr_pkg::ST_OUT : fthgr_pkg::ST_FILT_MUL;
                end
            end
            fthgr_pkg::ST_FILT_MUL:
            begin
                state_next = filter_primed_reg ? fthgr_pkg::ST_FILT_ACC : fthgr_pkg::ST_CHECK;
            end
            fthgr_pkg::ST_FILT_ACC:
            begin
                state_next = fthgr_pkg::ST_CHECK;
            end
            fthgr_pkg::ST_CHECK:
            begin
                priority if (need_drop)
                begin
                    state_next = fthgr_pkg::ST_DROP;
                end
                else if (!written_reg)
                begin
                    state_next = fthgr_pkg::ST_WRITE;
                end
                else
                begin
                    state_next = fthgr_pkg::ST_DIV_START;
                end
            end
            fthgr_pkg::ST_DROP:
            begin
                state_next = fthgr_pkg::ST_CHECK;
            end
            fthgr_pkg::ST_WRITE:
            begin
                state_next = fthgr_pkg::ST_CHECK;
            end
            fthgr_pkg::ST_DIV_START:
            begin
                state_next = fthgr_pkg::ST_DIV_WAIT;
            end
            fthgr_pkg::ST_DIV_WAIT:
            begin
                if (!div_busy)
                begin
                    state_next = fthgr_pkg::ST_HYST;
                end
            end
            fthgr_pkg::ST_HYST:
            begin
                state_next = fthgr_pkg::ST_STIFF_MUL;
            end
            fthgr_pkg::ST_STIFF_MUL:
            begin
                state_next = fthgr_pkg::ST_STIFF_ACC;
            end
            fthgr_pkg::ST_STIFF_ACC:
            begin
                state_next = fthgr_pkg::ST_DAMP_MUL;
            end
            fthgr_pkg::ST_DAMP_MUL:
            begin
                state_next = fthgr_pkg::ST_DAMP_ACC;
            end
            fthgr_pkg::ST_DAMP_ACC:
            begin
                state_next = fthgr_pkg::ST_OUT;
            end
            fthgr_pkg::ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = fthgr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fthgr_pkg::ST_IDLE;
            end
        endcase
    end

    // control outputs of the sequencer
    always_comb
    begin
        in_stall  = state_reg != fthgr_pkg::ST_IDLE;
        in_take   = (state_reg == fthgr_pkg::ST_IDLE) && in_valid;
        mem_we    = state_reg == fthgr_pkg::ST_WRITE;
        div_start = state_reg == fthgr_pkg::ST_DIV_START;
        out_load  = (state_reg == fthgr_pkg::ST_OUT) && (!out_valid_reg || !out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fthgr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enter_threshold_reg <= fthgr_pkg::ENTER_THRESHOLD_RST;
            exit_threshold_reg  <= fthgr_pkg::EXIT_THRESHOLD_RST;
            filter_coeff_reg    <= '0;
            window_length_reg   <= fthgr_pkg::WINDOW_LENGTH_RST;
            ramp_coeff_reg      <= '0;
            hold_stiffness_reg  <= '0;
            hold_damping_reg    <= '0;
            free_damping_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                fthgr_pkg::CFG_ENTER_THRESHOLD: enter_threshold_reg <= cfg_data;
                fthgr_pkg::CFG_EXIT_THRESHOLD:  exit_threshold_reg  <= cfg_data;
                fthgr_pkg::CFG_FILTER_COEFF:    filter_coeff_reg    <= cfg_data[CWF-1:0];
                fthgr_pkg::CFG_WINDOW_LENGTH:
                    window_length_reg <= cfg_data[fthgr_pkg::LEN_W-1:0];
                fthgr_pkg::CFG_RAMP_COEFF:      ramp_coeff_reg      <= cfg_data[CWF-1:0];
                fthgr_pkg::CFG_HOLD_STIFFNESS:  hold_stiffness_reg  <= cfg_data;
                fthgr_pkg::CFG_HOLD_DAMPING:    hold_damping_reg    <= cfg_data;
                fthgr_pkg::CFG_FREE_DAMPING:    free_damping_reg    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // block state and datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_flag_reg     <= 1'b0;
            filter_primed_reg <= 1'b0;
            filter_value_reg  <= '0;
            sum_reg           <= '0;
            count_reg         <= '0;
            head_reg          <= '0;
            tail_reg          <= '0;
            stiffness_reg     <= '0;
            damping_reg       <= '0;
            zero_ticks_reg    <= '0;
            written_reg       <= 1'b0;
            rise_reg          <= 1'b0;
            fall_reg          <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                fthgr_pkg::ST_IDLE:
                begin
                    if (in_take)
                    begin
                        rise_reg    <= 1'b0;
                        fall_reg    <= 1'b0;
                        written_reg <= 1'b0;
                        if (func)
                        begin
                            free_flag_reg     <= 1'b0;
                            filter_primed_reg <= 1'b0;
                            filter_value_reg  <= '0;
                            sum_reg           <= '0;
                            count_reg         <= '0;
                            head_reg          <= '0;
                            tail_reg          <= '0;
                            stiffness_reg     <= hold_stiffness_reg;
                            damping_reg       <= hold_damping_reg;
                        end
                        else if (force_norm == '0)
                        begin
                            if (zero_ticks_reg < fthgr_pkg::ZERO_SAT)
                            begin
                                zero_ticks_reg <= zero_ticks_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            zero_ticks_reg <= '0;
                        end
                    end
                end
                fthgr_pkg::ST_FILT_MUL:
                begin
                    // first sample after a restart primes the filter
                    if (!filter_primed_reg)
                    begin
                        filter_value_reg  <= x_reg;
                        filter_primed_reg <= 1'b1;
                    end
                end
                fthgr_pkg::ST_FILT_ACC:
                begin
                    filter_value_reg <= bl_result;
                end
                fthgr_pkg::ST_DROP:
                begin
                    sum_reg   <= sum_reg - SW'(rdata_reg);
                    count_reg <= count_reg - 1'b1;
                    tail_reg  <= (tail_reg == IW'(WINDOW_MAX - 1)) ? '0 : tail_reg + 1'b1;
                end
                fthgr_pkg::ST_WRITE:
                begin
                    sum_reg     <= sum_reg + SW'(filter_value_reg);
                    count_reg   <= count_reg + 1'b1;
                    head_reg    <= (head_reg == IW'(WINDOW_MAX - 1)) ? '0 : head_reg + 1'b1;
                    written_reg <= 1'b1;
                end
                fthgr_pkg::ST_HYST:
                begin
                    if (!free_flag_reg && (mean_reg >= enter_threshold_reg))
                    begin
                        free_flag_reg <= 1'b1;
                        rise_reg      <= 1'b1;
                    end
                    else if (free_flag_reg && (mean_reg < exit_threshold_reg))
                    begin
                        free_flag_reg <= 1'b0;
                        fall_reg      <= 1'b1;
                    end
                end
                fthgr_pkg::ST_STIFF_ACC:
                begin
                    stiffness_reg <= bl_result;
                end
                fthgr_pkg::ST_DAMP_ACC:
                begin
                    damping_reg <= bl_result;
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload registers of the datapath
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            x_reg <= force_norm;
            if (func)
            begin
                mean_reg <= '0;
            end
        end
        if ((state_reg == fthgr_pkg::ST_FILT_MUL) || (state_reg == fthgr_pkg::ST_STIFF_MUL)
            || (state_reg == fthgr_pkg::ST_DAMP_MUL))
        begin
            prod_reg <= bl_prod;
        end
        if ((state_reg == fthgr_pkg::ST_DIV_WAIT) && !div_busy)
        begin
            // the mean never exceeds the largest window entry
            mean_reg <= div_quotient[DW-1:0];
        end
    end

    // window store; the read port follows the oldest entry
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            window_mem[head_reg] <= filter_value_reg;
        end
        rdata_reg <= window_mem[tail_reg];
    end

    fthgr_div #(
        .DIVIDEND_W (SW),
        .DIVISOR_W  (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (count_reg),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            is_free_reg       <= free_flag_reg;
            became_free_reg   <= rise_reg;
            became_held_reg   <= fall_reg;
            filtered_norm_reg <= filter_value_reg;
            smoothed_norm_reg <= mean_reg;
            stiffness_out_reg <= stiffness_reg;
            damping_out_reg   <= damping_reg;
            zero_stuck_reg    <= zero_ticks_reg > fthgr_pkg::ZERO_LIMIT;
        end
    end

    assign out_valid     = out_valid_reg;
    assign is_free       = is_free_reg;
    assign became_free   = became_free_reg;
    assign became_held   = became_held_reg;
    assign filtered_norm = filtered_norm_reg;
    assign smoothed_norm = smoothed_norm_reg;
    assign stiffness_out = stiffness_out_reg;
    assign damping_out   = damping_out_reg;
    assign zero_stuck    = zero_stuck_reg;

endmodule

// ===== tb/force_trigger_hysteresis_gain_ramp_top_tb.sv =====
// self-checking testbench for force_trigger_hysteresis_gain_ramp_top: directed and random ticks,
// predicted per item by an in-bench scoreboard and compared field by field on every result
// depends on fthgr_pkg and the rtl of force_trigger_hysteresis_gain_ramp_top

module force_trigger_hysteresis_gain_ramp_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW = fthgr_pkg::DATA_W;
    localparam int CWF = fthgr_pkg::COEF_W;
    localparam int IDXW = fthgr_pkg::CFG_IDX_W;
    localparam int WIN_MAX = 256;
    localparam int RUN_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_PAUSE = 8;
    localparam int TAIL_CYCLES = 80;
    localparam int ZERO_RUN = 502;

    localparam logic FUNC_SAMPLE  = 1'b0;
    localparam logic FUNC_RESTART = 1'b1;

    typedef struct packed {
        logic          is_free;
        logic          became_free;
        logic          became_held;
        logic [DW-1:0] filtered;
        logic [DW-1:0] smoothed;
        logic [DW-1:0] stiffness;
        logic [DW-1:0] damping;
        logic          zero_stuck;
    } trigger_result_t;

    class trigger_scoreboard;
        // register copies
        logic [DW-1:0]                enter_th;
        logic [DW-1:0]                exit_th;
        logic [CWF-1:0]               filt_a;
        logic [fthgr_pkg::LEN_W-1:0]  win_len;
        logic [CWF-1:0]               ramp_a;
        logic [DW-1:0]                hold_stiff;
        logic [DW-1:0]                hold_damp;
        logic [DW-1:0]                free_damp;

        // block state
        logic                         free_st;
        logic                         primed;
        logic [DW-1:0]                filt_val;
        logic [DW-1:0]                win_mem [WIN_MAX];
        logic [31:0]                  win_sum;
        int unsigned                  win_cnt;
        int unsigned                  win_head;
        logic [DW-1:0]                stiff_now;
        logic [DW-1:0]                damp_now;
        logic [fthgr_pkg::ZCNT_W-1:0] zero_cnt;

        trigger_result_t              due_outputs [$];
        int                           errors;

        function new();
            enter_th = fthgr_pkg::ENTER_THRESHOLD_RST;
            exit_th = fthgr_pkg::EXIT_THRESHOLD_RST;
            filt_a = '0;
            win_len = fthgr_pkg::WINDOW_LENGTH_RST;
            ramp_a = '0;
            hold_stiff = '0;
            hold_damp = '0;
            free_damp = '0;
            free_st = 1'b0;
            primed = 1'b0;
            filt_val = '0;
            foreach (win_mem[i]) win_mem[i] = '0;
            win_sum = '0;
            win_cnt = 0;
            win_head = 0;
            stiff_now = '0;
            damp_now = '0;
            zero_cnt = '0;
            errors = 0;
        endfunction

        function void note_config(logic [IDXW-1:0] idx, logic [DW-1:0] data);
            case (idx)
                fthgr_pkg::CFG_ENTER_THRESHOLD: enter_th = data;
                fthgr_pkg::CFG_EXIT_THRESHOLD:  exit_th = data;
                fthgr_pkg::CFG_FILTER_COEFF:    filt_a = data[CWF-1:0];
                fthgr_pkg::CFG_WINDOW_LENGTH:   win_len = data[fthgr_pkg::LEN_W-1:0];
                fthgr_pkg::CFG_RAMP_COEFF:      ramp_a = data[CWF-1:0];
                fthgr_pkg::CFG_HOLD_STIFFNESS:  hold_stiff = data;
                fthgr_pkg::CFG_HOLD_DAMPING:    hold_damp = data;
                fthgr_pkg::CFG_FREE_DAMPING:    free_damp = data;
                default: ;
            endcase
        endfunction

        // c*old + (1-c)*new in q0.16, round half up
        function logic [DW-1:0] blend(logic [CWF-1:0] c, logic [DW-1:0] old_v,
                                      logic [DW-1:0] new_v);
            logic [47:0] acc;
            acc = 48'(c) * 48'(old_v) + (48'd65536 - 48'(c)) * 48'(new_v) + 48'd32768;
            return acc[39:16];
        endfunction

        function void drop_oldest();
            int unsigned slot;
            slot = (win_head + WIN_MAX - win_cnt) % WIN_MAX;
            win_sum -= 32'(win_mem[slot]);
            win_cnt--;
        endfunction

        function void take_tick(logic f, logic [DW-1:0] x);
            trigger_result_t r;
            int unsigned span;
            logic [31:0] mean;
            logic [DW-1:0] stiff_goal;
            logic [DW-1:0] damp_goal;
            r = '0;
            if (f == FUNC_RESTART)
            begin
                free_st = 1'b0;
                primed = 1'b0;
                filt_val = '0;
                win_sum = '0;
                win_cnt = 0;
                win_head = 0;
                stiff_now = hold_stiff;
                damp_now = hold_damp;
                r.stiffness = stiff_now;
                r.damping = damp_now;
                r.zero_stuck = (zero_cnt > fthgr_pkg::ZERO_LIMIT);
            end
            else
            begin
                if (x == '0)
                begin
                    if (zero_cnt < fthgr_pkg::ZERO_SAT)
                        zero_cnt++;
                end
                else
                    zero_cnt = '0;

                if (!primed)
                begin
                    filt_val = x;
                    primed = 1'b1;
                end
                else
                    filt_val = blend(filt_a, filt_val, x);

                span = win_len;
                if (span == 0)
                    span = 1;
                if (span > WIN_MAX)
                    span = WIN_MAX;
                if (win_cnt >= WIN_MAX)
                    drop_oldest();
                win_mem[win_head] = filt_val;
                win_head = (win_head + 1) % WIN_MAX;
                win_cnt++;
                win_sum += 32'(filt_val);
                while (win_cnt > span)
                    drop_oldest();
                mean = win_sum / win_cnt;

                if (!free_st && mean >= 32'(enter_th))
                begin
                    free_st = 1'b1;
                    r.became_free = 1'b1;
                end
                else if (free_st && mean < 32'(exit_th))
                begin
                    free_st = 1'b0;
                    r.became_held = 1'b1;
                end

                stiff_goal = free_st ? '0 : hold_stiff;
                damp_goal = free_st ? free_damp : hold_damp;
                stiff_now = blend(ramp_a, stiff_now, stiff_goal);
                damp_now = blend(ramp_a, damp_now, damp_goal);

                r.is_free = free_st;
                r.filtered = filt_val;
                r.smoothed = mean[DW-1:0];
                r.stiffness = stiff_now;
                r.damping = damp_now;
                r.zero_stuck = (zero_cnt > fthgr_pkg::ZERO_LIMIT);
            end
            due_outputs.insert(due_outputs.size(), r);
        endfunction

        task report(string what, logic [DW-1:0] got_v, logic [DW-1:0] want_v);
            errors++;
            $display("mismatch on %s: got 0x%0h, expected 0x%0h", what, got_v, want_v);
        endtask

        task check_tick_result(trigger_result_t got);
            trigger_result_t want;
            if (due_outputs.size() == 0)
            begin
                report("unexpected result", '0, '0);
                return;
            end
            want = due_outputs[0];
            due_outputs.delete(0);
            if (got.is_free !== want.is_free)
                report("is_free", got.is_free, want.is_free);
            if (got.became_free !== want.became_free)
                report("became_free", got.became_free, want.became_free);
            if (got.became_held !== want.became_held)
                report("became_held", got.became_held, want.became_held);
            if (got.filtered !== want.filtered)
                report("filtered_norm", got.filtered, want.filtered);
            if (got.smoothed !== want.smoothed)
                report("smoothed_norm", got.smoothed, want.smoothed);
            if (got.stiffness !== want.stiffness)
                report("stiffness_out", got.stiffness, want.stiffness);
            if (got.damping !== want.damping)
                report("damping_out", got.damping, want.damping);
            if (got.zero_stuck !== want.zero_stuck)
                report("zero_stuck", got.zero_stuck, want.zero_stuck);
        endtask

        function int pending();
            return due_outputs.size();
        endfunction
    endclass

    logic            clk = 1'b0;
    logic            rst_n;
    logic            cfg_we;
    logic [IDXW-1:0] cfg_index;
    logic [DW-1:0]   cfg_data;
    logic            in_valid;
    logic            in_stall;
    logic            func;
    logic [DW-1:0]   force_norm;
    logic            out_valid;
    logic            out_stall;
    logic            is_free;
    logic            became_free;
    logic            became_held;
    logic [DW-1:0]   filtered_norm;
    logic [DW-1:0]   smoothed_norm;
    logic [DW-1:0]   stiffness_out;
    logic [DW-1:0]   damping_out;
    logic            zero_stuck;

    trigger_scoreboard sb = new();
    trigger_result_t   observed;
    int                src_idle_pct = 0;
    int                sink_stall_pct = 0;
    int                hold_left = 0;
    int                cycle_count = 0;

    force_trigger_hysteresis_gain_ramp_top #(
        .WINDOW_MAX(WIN_MAX)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .func(func),
        .force_norm(force_norm),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .is_free(is_free),
        .became_free(became_free),
        .became_held(became_held),
        .filtered_norm(filtered_norm),
        .smoothed_norm(smoothed_norm),
        .stiffness_out(stiffness_out),
        .damping_out(damping_out),
        .zero_stuck(zero_stuck)
    );

    always #6 clk = ~clk;

    // result side: random stall, or a long hold-off when one is requested
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            observed.is_free = is_free;
            observed.became_free = became_free;
            observed.became_held = became_held;
            observed.filtered = filtered_norm;
            observed.smoothed = smoothed_norm;
            observed.stiffness = stiffness_out;
            observed.damping = damping_out;
            observed.zero_stuck = zero_stuck;
            sb.check_tick_result(observed);
        end
    end

    initial
    begin
        while (cycle_count < RUN_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    task automatic write_reg(input logic [IDXW-1:0] idx, input logic [DW-1:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        sb.note_config(idx, data);
    endtask

    task automatic config_done();
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_all(input logic [DW-1:0] enter_v, input logic [DW-1:0] exit_v,
                             input logic [DW-1:0] filt_v, input logic [DW-1:0] len_v,
                             input logic [DW-1:0] ramp_v, input logic [DW-1:0] hs_v,
                             input logic [DW-1:0] hd_v, input logic [DW-1:0] fd_v);
        write_reg(fthgr_pkg::CFG_ENTER_THRESHOLD, enter_v);
        write_reg(fthgr_pkg::CFG_EXIT_THRESHOLD, exit_v);
        write_reg(fthgr_pkg::CFG_FILTER_COEFF, filt_v);
        write_reg(fthgr_pkg::CFG_WINDOW_LENGTH, len_v);
        write_reg(fthgr_pkg::CFG_RAMP_COEFF, ramp_v);
        write_reg(fthgr_pkg::CFG_HOLD_STIFFNESS, hs_v);
        write_reg(fthgr_pkg::CFG_HOLD_DAMPING, hd_v);
        write_reg(fthgr_pkg::CFG_FREE_DAMPING, fd_v);
        config_done();
    endtask

    // coefficient writes carry random upper bits that the block must drop
    task automatic random_config(input int len_v);
        write_all(24'($urandom_range(0, 16000)), 24'($urandom_range(0, 12000)),
                  24'($urandom), 24'(len_v), 24'($urandom),
                  24'($urandom), 24'($urandom), 24'($urandom));
    endtask

    task automatic send_item(input logic f, input logic [DW-1:0] x);
        @(negedge clk);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        force_norm <= x;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.take_tick(f, x);
    endtask

    task automatic end_burst();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_PAUSE) @(posedge clk);
    endtask

    // mostly values near the thresholds so the hysteresis keeps switching
    function automatic logic [DW-1:0] pick_force();
        int unsigned sel;
        logic [DW-1:0] base;
        sel = $urandom_range(0, 9);
        base = (sel < 6) ? sb.enter_th : sb.exit_th;
        case (sel)
            0: return '0;
            1: return '1;
            2, 3: return 24'($urandom);
            default: return base + 24'($urandom_range(0, 2048)) - 24'd1024;
        endcase
    endfunction

    task automatic run_random(input int count, input int restart_pct, input int hold_at,
                              input int pause_at);
        for (int i = 0; i < count; i++)
        begin
            if (i == hold_at)
                hold_left = HOLD_CYCLES;
            if (i == pause_at)
            begin
                end_burst();
                wait_drained();
            end
            if ($urandom_range(0, 99) < restart_pct)
                send_item(FUNC_RESTART, 24'($urandom));
            else
                send_item(FUNC_SAMPLE, pick_force());
        end
        end_burst();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = fthgr_pkg::CFG_ENTER_THRESHOLD;
        cfg_data = '0;
        in_valid = 1'b0;
        func = FUNC_SAMPLE;
        force_norm = '0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // ticks straight out of reset, default registers
        send_item(FUNC_SAMPLE, 24'd0);
        send_item(FUNC_SAMPLE, 24'd5120);
        send_item(FUNC_SAMPLE, 24'hFFFFFF);
        send_item(FUNC_SAMPLE, 24'd2560);
        send_item(FUNC_SAMPLE, 24'd2559);
        send_item(FUNC_RESTART, 24'hABCDEF);
        send_item(FUNC_SAMPLE, 24'hFFFFFF);
        send_item(FUNC_RESTART, 24'h000000);
        end_burst();
        wait_drained();

        // all-ones registers but exit threshold and window length zero; length zero acts as one
        write_all(24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF,
                  24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_item(FUNC_RESTART, 24'h555555);
        send_item(FUNC_SAMPLE, 24'hFFFFFF);
        send_item(FUNC_SAMPLE, 24'h000000);
        send_item(FUNC_SAMPLE, 24'hFFFFFF);
        send_item(FUNC_SAMPLE, 24'h000001);
        end_burst();
        wait_drained();

        // enter at zero and exit at max toggle every tick; window above the store size
        write_all(24'h000000, 24'hFFFFFF, 24'h000000, 24'd300, 24'h000000,
                  24'h800000, 24'h7FFFFF, 24'hAAAAAA);
        send_item(FUNC_SAMPLE, 24'h123456);
        send_item(FUNC_SAMPLE, 24'hFEDCBA);
        send_item(FUNC_SAMPLE, 24'h000000);
        send_item(FUNC_SAMPLE, 24'hFFFFFF);
        send_item(FUNC_SAMPLE, 24'h5A5A5A);
        send_item(FUNC_SAMPLE, 24'hA5A5A5);
        send_item(FUNC_RESTART, 24'hFFFFFF);
        send_item(FUNC_SAMPLE, 24'h000100);
        send_item(FUNC_SAMPLE, 24'hFFFF00);
        send_item(FUNC_SAMPLE, 24'h0000FF);
        end_burst();
        wait_drained();

        src_idle_pct = 0;
        sink_stall_pct = 0;
        random_config(4);
        run_random(16, 5, -1, -1);

        // large samples then a long zero run: the filter decays slowly, the store
        // fills and wraps, the mean falls through both thresholds and the stuck flag rises
        wait_drained();
        src_idle_pct = 68;
        sink_stall_pct = 0;
        write_all(24'h400000, 24'h200000, 24'h5AFE00, 24'h0001FF, 24'h3CF000,
                  24'h400000, 24'h100000, 24'h020000);
        for (int i = 0; i < 6; i++)
            send_item(FUNC_SAMPLE, 24'($urandom_range(24'h800000, 24'hFFFFFF)));
        for (int i = 0; i < ZERO_RUN; i++)
            send_item(FUNC_SAMPLE, 24'd0);
        end_burst();

        // shrink the full window, then a restart keeps the zero count
        wait_drained();
        write_reg(fthgr_pkg::CFG_WINDOW_LENGTH, 24'd3);
        config_done();
        send_item(FUNC_SAMPLE, 24'd0);
        send_item(FUNC_RESTART, 24'($urandom));
        send_item(FUNC_SAMPLE, 24'd0);
        send_item(FUNC_SAMPLE, 24'($urandom_range(1, 24'hFFFFFF)));
        end_burst();

        // hold the result side off while items keep coming
        wait_drained();
        src_idle_pct = 0;
        sink_stall_pct = 68;
        random_config(3);
        run_random(16, 5, 2, 10);

        wait_drained();
        src_idle_pct = 26;
        sink_stall_pct = 26;
        random_config($urandom_range(1, 16));
        run_random(16, 8, -1, -1);

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
            sb.report("results never delivered", 24'(sb.pending()), '0);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
